FILE: hw/rtl/stream_perf_index_watchdog_top_defines.svh
// Assertion macros for the stream performance index watchdog.
// Used by the top level; no other dependencies.
`ifndef STREAM_PERF_INDEX_WATCHDOG_TOP_DEFINES_SVH
`define STREAM_PERF_INDEX_WATCHDOG_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPIW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPIW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPIW_ASSERT(lbl, prop, msg)
`define SPIW_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/spiw_pkg.sv
// Shared types and constants of the stream performance index watchdog.
// No dependencies.
`default_nettype none
package spiw_pkg;
  localparam int TABLE_ENTRIES_DEF   = 16;
  localparam int HISTORY_DEPTH_DEF   = 30;
  localparam int LOW_ALARM_LIMIT_DEF = 60;

  localparam logic signed [31:0] PERF_LIMIT_RST = 32'sd100;
  localparam logic signed [31:0] PERF_LIMIT_MAX = 32'sd100;
  localparam logic [63:0] TIMEOUT_RST = 64'd8000000000;

  localparam logic [1:0] REG_PERF_LIMIT = 2'd0;
  localparam logic [1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_OP_MODE    = 2'd2;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SLOT   = 2'd1;
  localparam logic [1:0] KIND_ALARM  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_CLR, ST_UPDATE, ST_LOWCHK,
    ST_HDR, ST_HIST, ST_ALARM
  } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/spiw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module spiw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/stream_perf_index_watchdog_top.sv
// Top level of the stream performance index watchdog.
// Depends on spiw_pkg, spiw_ram and stream_perf_index_watchdog_top_defines.svh.
`default_nettype none
`include "stream_perf_index_watchdog_top_defines.svh"
// Usage:
// A command (sample, delete, clear table) is taken when start is high and busy
// is low. Configuration (perf_limit, timeout_ns, op_mode) is written through
// cfg_we/cfg_index/cfg_data while busy is low; a perf_limit above 100 is ignored.
// Results leave on the output ports, marked by strobe for one cycle; last
// marks the final result of a command. The receiver cannot stall.
// Sequence of each command, with N table entries and H history slots:
//   clear or undefined command: busy never rises.
//   delete or dropped sample: serial scan of the record RAM.
//   sample that hits: scan, then update; a new stream adds a clear of its H history slots.
//   a timeout report adds a header, then one slot per history read;
//   an alarm adds one alarm result.
// The scan of the record RAM reads one entry a cycle.
// Reset empties the table (valid bits in flops); RAM contents need no clearing.
module stream_perf_index_watchdog_top
  import spiw_pkg::*;
#(
  parameter int TABLE_ENTRIES   = spiw_pkg::TABLE_ENTRIES_DEF,
  parameter int HISTORY_DEPTH   = spiw_pkg::HISTORY_DEPTH_DEF,
  parameter int LOW_ALARM_LIMIT = spiw_pkg::LOW_ALARM_LIMIT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         command,
  input  wire logic [21:0]        proc_id,
  input  wire logic [63:0]        buf_key,
  input  wire logic signed [31:0] perf_value,
  input  wire logic [63:0]        now_ns,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  output logic                    strobe,
  output logic [1:0]              kind,
  output logic [21:0]             out_proc_id,
  output logic [63:0]             out_buf_key,
  output logic [31:0]             error_count,
  output logic [63:0]             error_start_ns,
  output logic signed [31:0]      slot_value,
  output logic [63:0]             slot_time_ns,
  output logic [2:0]              mode_report,
  output logic                    last
);
  localparam int N   = TABLE_ENTRIES;
  localparam int HD  = HISTORY_DEPTH;
  localparam int IW  = (N > 1) ? $clog2(N) : 1;
  localparam int SW  = $clog2(HD);
  localparam int HN  = N * HD;
  localparam int HAW = $clog2(HN);
  localparam int ENT_W = 22 + 64 + SW + 32 + 64;
  localparam int HIST_W = 32 + 64;

  // configuration
  logic signed [31:0] perf_limit;
  logic [63:0]        timeout_ns;
  logic [2:0]         op_mode;

  // latched command
  logic [1:0]         cmd;
  logic [21:0]        pid;
  logic [63:0]        key;
  logic signed [31:0] perf;
  logic [63:0]        now;

  state_t state, state_next;

  // per-entry flags in flops
  logic [N-1:0]  entry_valid;
  logic [N-1:0]  entry_pos;
  logic [IW-1:0] entry_age [N];
  logic [IW:0]   alloc_seq;
  logic [5:0]    low_alarm_count;

  // scan bookkeeping
  logic [IW:0]   scnt;
  logic          sv;
  logic [IW-1:0] sidx;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [IW-1:0] best_age;

  // working record
  logic [21:0]   rec_proc;
  logic [63:0]   rec_buf;
  logic [SW-1:0] rec_wslot;
  logic [31:0]   rec_cnt;
  logic [63:0]   rec_start;

  logic          to_flag;
  logic [31:0]   hdr_cnt;
  logic [63:0]   hdr_start;
  logic          alarm_pend;

  logic [SW:0]   hcnt;
  logic          rd_v;
  logic          rd_last;

  // RAM ports
  logic              ent_we;
  logic [IW-1:0]     ent_waddr, ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata;
  logic              hist_we;
  logic [HAW-1:0]    hist_waddr, hist_raddr;
  logic [HIST_W-1:0] hist_wdata, hist_rdata;

  spiw_ram #(.WIDTH(ENT_W), .DEPTH(N)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  spiw_ram #(.WIDTH(HIST_W), .DEPTH(HN)) u_hist_ram (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  // fields of the record read during the scan
  logic [21:0] rd_proc;
  logic [63:0] rd_buf;
  assign rd_proc = ent_rdata[ENT_W-1 -: 22];
  assign rd_buf  = ent_rdata[ENT_W-23 -: 64];

  logic is_del;
  assign is_del = (cmd == CMD_DELETE);

  // a sample or delete that starts a table scan
  logic take_work;
  assign take_work = start && !busy && (command == CMD_SAMPLE || command == CMD_DELETE);

  logic scan_hit;
  assign scan_hit = sv && entry_valid[sidx] && (rd_proc == pid) &&
                    ((rd_buf == key) || (!is_del && rd_buf == 64'd0)) &&
                    (!found || entry_age[sidx] < best_age);

  // first free entry
  logic [IW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!entry_valid[i]) free_idx = IW'(i);
    end
  end

  logic table_full;
  assign table_full = (alloc_seq == (IW+1)'(N));

  logic [HAW-1:0] base;
  assign base = HAW'(best_idx) * HAW'(HD);

  // sample update arithmetic
  logic [63:0]   buf_f;
  logic [SW-1:0] slot, wslot_n;
  logic          high;
  logic [31:0]   cnt_inc, cnt_n;
  logic [63:0]   start_n;
  logic          to_n;
  always_comb begin
    buf_f   = (rec_buf == 64'd0) ? key : rec_buf;
    slot    = (rec_wslot > SW'(HD - 1)) ? '0 : rec_wslot;
    wslot_n = (slot > SW'(HD - 2)) ? '0 : slot + 1'b1;
    high    = (perf >= perf_limit);
    cnt_inc = (rec_cnt == 32'hFFFF_FFFF) ? rec_cnt : rec_cnt + 32'd1;
    to_n    = 1'b0;
    cnt_n   = '0;
    start_n = '0;
    if (high) begin
      if (rec_cnt != 32'd0) begin
        to_n = ((now - rec_start) > timeout_ns);
        if (!to_n) begin
          cnt_n   = cnt_inc;
          start_n = rec_start;
        end
      end else begin
        cnt_n   = 32'd1;
        start_n = now;
      end
    end
  end

  // low-index check over the flag flops
  logic pass;
  logic [5:0] lac_inc;
  assign pass    = |(entry_valid & entry_pos);
  assign lac_inc = low_alarm_count + 6'd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take_work) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sv && sidx == IW'(N - 1)) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (is_del) state_next = ST_IDLE;
        else if (found) state_next = ST_UPDATE;
        else if (table_full) state_next = ST_IDLE;
        else state_next = ST_CLR;
      end
      ST_CLR: begin
        if (hcnt == (SW+1)'(HD - 1)) state_next = ST_UPDATE;
      end
      ST_UPDATE: state_next = ST_LOWCHK;
      ST_LOWCHK: begin
        if (to_flag) state_next = ST_HDR;
        else if (op_mode != 3'd0 && !pass && lac_inc >= 6'(LOW_ALARM_LIMIT)) begin
          state_next = ST_ALARM;
        end else state_next = ST_IDLE;
      end
      ST_HDR: state_next = ST_HIST;
      ST_HIST: begin
        if (rd_v && rd_last) state_next = alarm_pend ? ST_ALARM : ST_IDLE;
      end
      ST_ALARM: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    ent_we     = 1'b0;
    ent_waddr  = best_idx;
    ent_wdata  = {rec_proc, buf_f, wslot_n, cnt_n, start_n};
    ent_raddr  = scnt[IW-1:0];
    hist_we    = 1'b0;
    hist_waddr = base + HAW'(hcnt);
    hist_wdata = '0;
    hist_raddr = base + HAW'(hcnt);
    case (state)
      ST_CLR: hist_we = 1'b1;
      ST_UPDATE: begin
        ent_we     = 1'b1;
        hist_we    = 1'b1;
        hist_waddr = base + HAW'(slot);
        hist_wdata = {perf, now};
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      perf_limit <= PERF_LIMIT_RST;
      timeout_ns <= TIMEOUT_RST;
      op_mode    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERF_LIMIT: begin
          if ($signed(cfg_data[31:0]) <= PERF_LIMIT_MAX) perf_limit <= cfg_data[31:0];
        end
        REG_TIMEOUT: timeout_ns <= cfg_data;
        REG_OP_MODE: op_mode <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // control and table flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      entry_valid     <= '0;
      entry_pos       <= '0;
      alloc_seq       <= '0;
      low_alarm_count <= '0;
      sv              <= 1'b0;
      found           <= 1'b0;
      rd_v            <= 1'b0;
      alarm_pend      <= 1'b0;
      to_flag         <= 1'b0;
      strobe          <= 1'b0;
      scnt            <= '0;
      hcnt            <= '0;
      for (int i = 0; i < N; i++) entry_age[i] <= '0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          scnt  <= '0;
          sv    <= 1'b0;
          found <= 1'b0;
          if (start && command == CMD_CLEAR) begin
            entry_valid <= '0;
            alloc_seq   <= '0;
          end
        end
        ST_SCAN: begin
          // one read issued and one record compared each cycle
          if (scnt != (IW+1)'(N)) scnt <= scnt + 1'b1;
          sv   <= (scnt != (IW+1)'(N));
          sidx <= scnt[IW-1:0];
          if (scan_hit) begin
            found    <= 1'b1;
            best_idx <= sidx;
            best_age <= entry_age[sidx];
          end
        end
        ST_DECIDE: begin
          hcnt <= '0;
          if (is_del) begin
            if (found) begin
              for (int i = 0; i < N; i++) begin
                if (entry_valid[i] && entry_age[i] > best_age) begin
                  entry_age[i] <= entry_age[i] - 1'b1;
                end
              end
              entry_valid[best_idx] <= 1'b0;
              alloc_seq <= alloc_seq - 1'b1;
            end
          end else if (!found && !table_full) begin
            // allocate the first free entry as the newest
            for (int i = 0; i < N; i++) begin
              if (entry_valid[i]) entry_age[i] <= entry_age[i] + 1'b1;
            end
            entry_age[free_idx]   <= '0;
            entry_valid[free_idx] <= 1'b1;
            alloc_seq <= alloc_seq + 1'b1;
            best_idx  <= free_idx;
          end
        end
        ST_CLR: hcnt <= hcnt + 1'b1;
        ST_UPDATE: begin
          entry_pos[best_idx] <= (perf > 32'sd0);
          to_flag <= to_n;
        end
        ST_LOWCHK: begin
          hcnt <= '0;
          rd_v <= 1'b0;
          alarm_pend <= 1'b0;
          if (op_mode != 3'd0) begin
            if (pass) low_alarm_count <= '0;
            else if (lac_inc >= 6'(LOW_ALARM_LIMIT)) begin
              low_alarm_count <= '0;
              alarm_pend      <= 1'b1;
            end else low_alarm_count <= lac_inc;
          end
        end
        ST_HDR: strobe <= 1'b1;
        ST_HIST: begin
          // slot reads issued in storage order, emitted through the RAM read register and the output register
          if (hcnt != (SW+1)'(HD)) hcnt <= hcnt + 1'b1;
          rd_v    <= (hcnt != (SW+1)'(HD));
          rd_last <= (hcnt == (SW+1)'(HD - 1));
          if (rd_v) strobe <= 1'b1;
        end
        ST_ALARM: strobe <= 1'b1;
        default: ;
      endcase
    end
  end

  // command latch, working record and result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd  <= command;
      pid  <= proc_id;
      key  <= buf_key;
      perf <= perf_value;
      now  <= now_ns;
    end
    if (state == ST_SCAN && scan_hit) begin
      {rec_proc, rec_buf, rec_wslot, rec_cnt, rec_start} <= ent_rdata;
    end
    if (state == ST_DECIDE && !found) begin
      rec_proc  <= pid;
      rec_buf   <= key;
      rec_wslot <= '0;
      rec_cnt   <= '0;
      rec_start <= '0;
    end
    if (state == ST_UPDATE) begin
      rec_buf   <= buf_f;
      hdr_cnt   <= cnt_inc;
      hdr_start <= rec_start;
    end
    case (state)
      ST_HDR: begin
        kind           <= KIND_HEADER;
        out_proc_id    <= rec_proc;
        out_buf_key    <= rec_buf;
        error_count    <= hdr_cnt;
        error_start_ns <= hdr_start;
        slot_value     <= '0;
        slot_time_ns   <= '0;
        mode_report    <= '0;
        last           <= 1'b0;
      end
      ST_HIST: begin
        kind           <= KIND_SLOT;
        error_count    <= '0;
        error_start_ns <= '0;
        slot_value     <= hist_rdata[95:64];
        slot_time_ns   <= hist_rdata[63:0];
        last           <= rd_last && !alarm_pend;
      end
      ST_ALARM: begin
        kind           <= KIND_ALARM;
        out_proc_id    <= rec_proc;
        out_buf_key    <= rec_buf;
        error_count    <= '0;
        error_start_ns <= '0;
        slot_value     <= '0;
        slot_time_ns   <= '0;
        mode_report    <= op_mode;
        last           <= 1'b1;
      end
      default: ;
    endcase
  end

  // checks
  `SPIW_ASSERT(a_strobe_from_work, strobe |-> $past(state != ST_IDLE), "result outside a command")
  `SPIW_ASSERT(a_count_matches, $countones(entry_valid) == 32'(alloc_seq), "entry count drift")
  `SPIW_ASSERT_NXT(a_cmd_busy, take_work, busy, "command not taken")
  `SPIW_ASSERT_NXT(a_clear_empties, start && !busy && command == CMD_CLEAR, entry_valid == '0, "clear left entries")
endmodule
`default_nettype wire
